// ----- design/adagrad_pkg.sv -----
// Package: shared types and constants for the adagrad parameter update block.
`timescale 1ns / 1ps
package adagrad_pkg;
  localparam int unsigned LR_W = 24;
  localparam logic [LR_W-1:0] LR_RESET = 24'd6554;
  localparam logic [63:0] EPS_Q32 = 64'd4295;
  // gradient magnitude width (magnitude is up to 2^31)
  localparam int unsigned MAG_W = 32;
  localparam int unsigned NUM_W = LR_W + MAG_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_ACC   = 7'b0000100,
    ST_SQRT  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_RES   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;
endpackage

// ----- design/adagrad_parameter_update.sv -----
// Top level: AdaGrad parameter update with a squared-gradient accumulator memory.
`timescale 1ns / 1ps
// One item is taken at a time; after accept, an item with an index in range passes
// through the accumulator memory read, the squared-gradient add and write-back,
// the bit-serial square root (32 steps of one root bit each, then a step that
// loads the divider), 56 steps of the restoring divider (one quotient bit per
// cycle) and the final add and saturation. The result then holds until taken,
// and the next item can be accepted in the cycle after that, so a new item is
// never taken before the last result has been. After reset the accumulator memory
// is cleared by a pass over all ENTRIES entries, during which no item is taken.
// Indexes at or above ENTRIES leave the store alone and pass param_value through.
module adagrad_parameter_update #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,        // learning_rate
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,        // element_index[9:0], param_value[41:10],
                                       // gradient[73:42], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,       // new_param
  output logic        out_tuser        // saturated
);
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NW = adagrad_pkg::NUM_W;

  adagrad_pkg::state_t state_r, state_nxt;

  logic [63:0] mem [ENTRIES];
  logic [63:0] rd_data_r;
  logic        clr_busy_r;
  logic [AW:0] clr_cnt_r;

  logic [adagrad_pkg::LR_W-1:0] lr_r;
  logic [AW-1:0] idx_r;
  logic          in_range_r;
  logic signed [31:0] p_r;
  logic        neg_r;
  logic [31:0] mag_r;
  logic [63:0] acc_r;
  logic        sat_r;
  // square root
  logic [63:0] sq_v_r, sq_r_r, sq_bit_r;
  // divider
  logic [NW-1:0] q_r;
  logic [32:0]   rem_r;
  logic [5:0]    cnt_r;
  logic [31:0]   root_r;
  logic signed [31:0] res_r;
  logic        osat_r;

  logic [9:0]  in_idx;
  logic [63:0] sq;
  logic [64:0] acc_sum, eps_sum;
  logic [63:0] sq_trial;
  logic [33:0] rem_sh;
  logic signed [33:0] res_wide;

  assign in_idx    = in_tdata[9:0];
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == adagrad_pkg::ST_IDLE) && !clr_busy_r;
  assign out_tvalid = (state_r == adagrad_pkg::ST_OUT);
  assign out_tdata  = res_r;
  assign out_tuser  = osat_r;

  assign sq       = mag_r * mag_r;
  assign acc_sum  = {1'b0, rd_data_r} + {1'b0, sq};
  assign eps_sum  = {1'b0, acc_r} + {1'b0, adagrad_pkg::EPS_Q32};
  assign sq_trial = sq_r_r + sq_bit_r;
  assign rem_sh   = {rem_r, q_r[NW-1]};
  assign res_wide = neg_r ? ({{2{p_r[31]}}, p_r} + {2'b00, q_r[31:0]})
                          : ({{2{p_r[31]}}, p_r} - {2'b00, q_r[31:0]});

  // Sequence one item
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      adagrad_pkg::ST_IDLE: if (in_tvalid && in_tready) state_nxt = adagrad_pkg::ST_READ;
      adagrad_pkg::ST_READ: state_nxt = in_range_r ? adagrad_pkg::ST_ACC
                                                   : adagrad_pkg::ST_RES;
      adagrad_pkg::ST_ACC:  state_nxt = adagrad_pkg::ST_SQRT;
      adagrad_pkg::ST_SQRT: if (sq_bit_r == 64'd0) state_nxt = adagrad_pkg::ST_DIV;
      adagrad_pkg::ST_DIV:  if (cnt_r == 6'd0) state_nxt = adagrad_pkg::ST_RES;
      adagrad_pkg::ST_RES:  state_nxt = adagrad_pkg::ST_OUT;
      adagrad_pkg::ST_OUT:  if (out_tready) state_nxt = adagrad_pkg::ST_IDLE;
      default:              state_nxt = adagrad_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= adagrad_pkg::ST_IDLE;
      lr_r       <= adagrad_pkg::LR_RESET;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) lr_r <= cfg_data;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AW+1)'(ENTRIES - 1)) clr_busy_r <= 1'b0;
      end
    end
  end

  // Accumulator memory: clear pass, read at accept, write back after the add
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r[AW-1:0]] <= 64'd0;
    end else if (state_r == adagrad_pkg::ST_ACC) begin
      mem[idx_r] <= acc_r;
    end
    rd_data_r <= mem[AW'(in_idx)];
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      adagrad_pkg::ST_IDLE: begin
        idx_r      <= AW'(in_idx);
        in_range_r <= ({22'd0, in_idx} < 32'(ENTRIES));
        p_r        <= in_tdata[41:10];
        neg_r      <= in_tdata[73];
        mag_r      <= in_tdata[73] ? (32'd0 - in_tdata[73:42]) : in_tdata[73:42];
        sat_r      <= 1'b0;
      end
      adagrad_pkg::ST_READ: begin
        acc_r <= acc_sum[64] ? '1 : acc_sum[63:0];
        sat_r <= acc_sum[64];
      end
      adagrad_pkg::ST_ACC: begin
        sq_v_r   <= eps_sum[64] ? '1 : eps_sum[63:0];
        sat_r    <= sat_r | eps_sum[64];
        sq_r_r   <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      adagrad_pkg::ST_SQRT: begin
        // one root bit per cycle
        if (sq_bit_r != 64'd0) begin
          if (sq_v_r >= sq_trial) begin
            sq_v_r <= sq_v_r - sq_trial;
            sq_r_r <= (sq_r_r >> 1) + sq_bit_r;
          end else begin
            sq_r_r <= sq_r_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
        end else begin
          root_r <= sq_r_r[31:0];
          q_r    <= lr_r * mag_r;
          rem_r  <= '0;
          cnt_r  <= 6'(NW - 1);
        end
      end
      adagrad_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if ({1'b0, rem_sh} >= {3'd0, root_r}) begin
          rem_r <= 33'(rem_sh - {2'd0, root_r});
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[32:0];
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      adagrad_pkg::ST_RES: begin
        if (!in_range_r) begin
          res_r  <= p_r;
          osat_r <= 1'b0;
        end else if (q_r[NW-1:32] != '0 || res_wide > 34'sh0_7FFF_FFFF) begin
          res_r  <= neg_r ? 32'h7FFF_FFFF : 32'h8000_0000;
          osat_r <= 1'b1;
        end else if (res_wide < -34'sh0_8000_0000) begin
          res_r  <= 32'h8000_0000;
          osat_r <= 1'b1;
        end else begin
          res_r  <= res_wide[31:0];
          osat_r <= sat_r;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready) else $error("item accepted during clear pass");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == adagrad_pkg::ST_DIV |-> root_r != 32'd0) else $error("zero root");
endmodule

// ----- sim/testbench.sv -----
// Testbench for the AdaGrad parameter update block: table of directed beats, then random traffic.
`timescale 1ns / 1ps
module testbench;
  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned N_RANDOM = 630;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [63:0] EPS_RAW = 64'd4295;

  typedef struct packed {
    logic [31:0] new_param;
    logic        saturated;
  } update_t;

  typedef struct {
    logic [9:0]  idx;
    logic [31:0] param;
    logic [31:0] grad;
    bit          known;     // expected value typed in the row
    update_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  // Predictor state
  logic [63:0] acc_model [ENTRIES];
  logic [23:0] lr_model;
  update_t     pending_updates [$];

  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned cycle_count = 0;
  bit          sink_idle_on = 1'b1;
  bit          hold_sink = 1'b0;

  adagrad_parameter_update #(.ENTRIES(ENTRIES)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #10 clk = ~clk;

  // Bit-serial integer square root, floor
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Compute one update and advance the accumulator copy
  function automatic update_t predict_update(input logic [9:0] idx,
                                             input logic [31:0] param,
                                             input logic [31:0] grad);
    update_t u;
    logic [63:0] mag, sq, acc, sum, rt, stp;
    logic signed [63:0] res;
    bit sat;
    sat = 1'b0;
    res = {{32{param[31]}}, param};
    if (idx < ENTRIES) begin
      mag = grad[31] ? (64'h1_0000_0000 - {32'd0, grad}) : {32'd0, grad};
      sq = mag * mag;
      acc = acc_model[idx];
      if (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
        acc = 64'hFFFF_FFFF_FFFF_FFFF;
        sat = 1'b1;
      end else begin
        acc = acc + sq;
      end
      acc_model[idx] = acc;
      if (acc > 64'hFFFF_FFFF_FFFF_FFFF - EPS_RAW) begin
        sum = 64'hFFFF_FFFF_FFFF_FFFF;
        sat = 1'b1;
      end else begin
        sum = acc + EPS_RAW;
      end
      rt = root_floor(sum);
      stp = ({40'd0, lr_model} * mag) / rt;
      res = grad[31] ? res + $signed(stp) : res - $signed(stp);
      if (res > 64'sh7FFF_FFFF) begin
        res = 64'sh7FFF_FFFF;
        sat = 1'b1;
      end else if (res < -64'sh8000_0000) begin
        res = -64'sh8000_0000;
        sat = 1'b1;
      end
    end
    u.new_param = res[31:0];
    u.saturated = sat;
    return u;
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result sink: random stalls, optional long hold-off
  initial begin
    int unsigned gap;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        // Long hold-off, counted here while the source keeps offering beats
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    update_t exp_u;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (out_tuser) sat_seen <= sat_seen + 1;
      if (pending_updates.size() == 0) begin
        $error("unexpected result beat new_param=%h saturated=%b", out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_u = pending_updates.pop_front();
        if (out_tdata !== exp_u.new_param) begin
          $error("new_param expected %h actual %h", exp_u.new_param, out_tdata);
          error_count++;
        end
        if (out_tuser !== exp_u.saturated) begin
          $error("saturated expected %b actual %b", exp_u.saturated, out_tuser);
          error_count++;
        end
      end
    end
  end

  // Send one beat; queue its expectation at acceptance
  task automatic send_update(input logic [9:0] idx, input logic [31:0] param,
                             input logic [31:0] grad, input bit idle_ok,
                             input bit known, input update_t want);
    update_t u;
    int unsigned gap;
    if (idle_ok && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, grad, param, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    u = predict_update(idx, param, grad);
    if (known && u !== want) begin
      $error("table row expected new_param %h saturated %b, predictor %h %b",
             want.new_param, want.saturated, u.new_param, u.saturated);
      error_count++;
    end
    pending_updates = {pending_updates, u};
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_rate(input logic [23:0] lr);
    cfg_valid <= 1'b1;
    cfg_data <= lr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lr_model = lr;
  endtask

  // Random update, mostly small indexes to revisit accumulators
  task automatic send_random(input bit idle_ok);
    logic [9:0] idx;
    logic [31:0] p, g;
    case ($urandom_range(0, 9))
      0: idx = 10'(ENTRIES - 1 - $urandom_range(0, 3));
      1, 2: idx = 10'($urandom);
      default: idx = 10'($urandom_range(0, 15));
    endcase
    p = $urandom;
    case ($urandom_range(0, 7))
      0: g = '0;
      1: g = $urandom;
      2: g = {1'b1, 31'($urandom_range(0, 3))};
      3: g = {1'b0, {31{1'b1}}} - $urandom_range(0, 3);
      default: g = 32'($signed(16'($urandom)));
    endcase
    send_update(idx, p, g, idle_ok, 1'b0, '0);
  endtask

  stim_row_t directed_rows [$];

  initial begin
    stim_row_t r;
    int unsigned phase;
    logic [23:0] rate_set [4];
    for (int i = 0; i < ENTRIES; i++) acc_model[i] = '0;
    lr_model = adagrad_pkg::LR_RESET;

    // Zero gradients at fresh entries: value passes through unchanged
    r = '{10'd0, 32'h0001_0000, 32'h0, 1'b1, '{32'h0001_0000, 1'b0}};
    directed_rows = {directed_rows, r};
    r = '{10'd1023, 32'h8000_0000, 32'h0, 1'b1, '{32'h8000_0000, 1'b0}};
    directed_rows = {directed_rows, r};
    r = '{10'd5, 32'h7FFF_FFFF, 32'h0, 1'b1, '{32'h7FFF_FFFF, 1'b0}};
    directed_rows = {directed_rows, r};
    // Gradient extremes and signs
    r = '{10'd2, 32'h0, 32'h8000_0000, 1'b0, '0}; directed_rows = {directed_rows, r};
    r = '{10'd3, 32'h0, 32'h7FFF_FFFF, 1'b0, '0}; directed_rows = {directed_rows, r};
    r = '{10'd4, 32'h0001_0000, 32'h0001_0000, 1'b0, '0};
    directed_rows = {directed_rows, r};
    r = '{10'd4, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0, '0};
    directed_rows = {directed_rows, r};
    r = '{10'd6, 32'h0, 32'h0000_0001, 1'b0, '0}; directed_rows = {directed_rows, r};
    r = '{10'd7, 32'h0, 32'hFFFF_FFFF, 1'b0, '0}; directed_rows = {directed_rows, r};
    // Result saturation near both rails
    r = '{10'd8, 32'h8000_0000, 32'h0000_0100, 1'b0, '0};
    directed_rows = {directed_rows, r};
    r = '{10'd9, 32'h7FFF_FFFF, 32'hFFFF_FF00, 1'b0, '0};
    directed_rows = {directed_rows, r};
    // Drive one accumulator toward saturation with repeated large gradients
    for (int k = 0; k < 6; k++) begin
      r = '{10'd10, 32'h1234_5678, 32'h8000_0000, 1'b0, '0};
      directed_rows = {directed_rows, r};
    end
    r = '{10'd10, 32'h0, 32'h0, 1'b0, '0}; directed_rows = {directed_rows, r};
    r = '{10'd10, 32'h5555_AAAA, 32'h7FFF_FFFF, 1'b0, '0};
    directed_rows = {directed_rows, r};
    r = '{10'd1022, 32'hAAAA_5555, 32'h8000_0001, 1'b0, '0};
    directed_rows = {directed_rows, r};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset rate
    foreach (directed_rows[i])
      send_update(directed_rows[i].idx, directed_rows[i].param, directed_rows[i].grad,
                  1'b1, directed_rows[i].known, directed_rows[i].want);
    drain_results();

    // Random phases across learning rates, extremes included
    rate_set[0] = 24'hFFFFFF;
    rate_set[1] = 24'd0;
    rate_set[2] = 24'd65536;
    rate_set[3] = 24'($urandom);
    for (phase = 0; phase < 4; phase++) begin
      write_rate(rate_set[phase]);
      for (int n = 0; n < N_RANDOM / 5; n++) send_random(1'b1);
      // Long receiver hold-off on the first phase while beats keep coming
      if (phase == 0) begin
        hold_sink = 1'b1;
        for (int n = 0; n < 4; n++) send_random(1'b0);
        while (hold_sink) @(posedge clk);
      end
      // Pause the source until every result is back
      drain_results();
    end

    // Final stretch with no idling on either side
    write_rate(24'd6554);
    sink_idle_on = 1'b0;
    for (int n = 0; n < N_RANDOM / 5; n++) send_random(1'b0);
    drain_results();

    $display("Covered %0d result beats (%0d saturated) over %0d rate settings,",
             results_seen, sat_seen, 5);
    $display("with zero/extreme gradients, top and bottom indexes, and long stalls.");
    if (error_count == 0 && pending_updates.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/adagrad_pkg.sv
design/adagrad_parameter_update.sv
sim/testbench.sv
